// ===== src/zbgp_pkg.sv =====
// ----------------------------------------------------------------------------
// Zero byte group packer package
// Shared types and constants for the group packer controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package zbgp_pkg;

   localparam int RunLimitDef     = 7;
   localparam int GroupBytes      = 8;
   localparam int ThresholdW      = 4;
   localparam logic [ThresholdW-1:0] ThresholdReset = 4'd6;

   typedef struct packed {
      logic [63:0] group_data;
      logic [3:0]  byte_count;
      logic        stream_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       burst_last;
      logic       stream_end;
   } rsp_type;

   // Source of the byte loaded into the output register.
   typedef enum logic [2:0] {
      SRC_COUNT,
      SRC_WORD,
      SRC_RAW,
      SRC_HDR,
      SRC_NZ
   } src_type;

   typedef struct packed {
      logic    capture;
      logic    store_word;
      logic    start_flush;
      logic    flush_plus1;
      logic    emit;
      src_type src;
      logic    final_byte;
   } ctl_cmd_type;

   typedef struct packed {
      logic run_active;
      logic join_run;
      logic end_cond;
      logic flush_empty;
      logic words_done;
      logic byte_last;
      logic raw_empty;
      logic raw_final;
      logic mask_empty;
      logic mask_single;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== src/zbgp_datapath.sv =====
// ----------------------------------------------------------------------------
// Zero byte group packer datapath
// Holds the captured group, run state, raw run buffer and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module zbgp_datapath #(
   parameter int RunLimit = zbgp_pkg::RunLimitDef
) (
   input  wire                             clock,
   input  wire                             reset,
   input  zbgp_pkg::req_type               req_data,
   input  wire                             csr_valid,
   input  wire [zbgp_pkg::ThresholdW-1:0]  csr_data,
   input  zbgp_pkg::ctl_cmd_type           cmd,
   output zbgp_pkg::dp_status_type         status,
   input  wire                             rsp_stall,
   output logic                            rsp_valid,
   output zbgp_pkg::rsp_type               rsp_data
);

   localparam int LenW  = $clog2(RunLimit + 1);
   localparam int AddrW = (RunLimit > 1) ? $clog2(RunLimit) : 1;

   // Control state.
   logic                            run_active_ff, run_active_in;
   logic [LenW-1:0]                 run_length_ff, run_length_in;
   logic [zbgp_pkg::ThresholdW-1:0] threshold_ff, threshold_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   // Payload state.
   logic [63:0]     data_ff, data_in;
   logic [3:0]      count_ff, count_in;
   logic            last_ff, last_in;
   logic [7:0]      mask_ff, mask_in;
   logic [3:0]      nz_ff, nz_in;
   logic [2:0]      byte_idx_ff, byte_idx_in;
   logic [LenW-1:0] word_idx_ff, word_idx_in;
   logic [LenW-1:0] flush_len_ff, flush_len_in;
   logic [LenW-1:0] flush_cnt_ff, flush_cnt_in;
   logic [63:0]     rdata_ff;
   zbgp_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [63:0] run_mem [RunLimit];

   logic [3:0]      cap_count;
   logic [7:0]      cap_mask;
   logic [3:0]      cap_nz;
   logic [2:0]      low_idx;
   logic [7:0]      emit_byte;
   logic [63:0]     word_shift, data_shift, low_shift;
   logic [LenW:0]   len_plus1, word_plus1;

   // Capture-side decoding of the incoming group.
   always_comb begin
      cap_count = (req_data.byte_count > 4'(zbgp_pkg::GroupBytes)) ?
                  4'(zbgp_pkg::GroupBytes) : req_data.byte_count;
      cap_nz    = '0;
      for (int i = 0; i < zbgp_pkg::GroupBytes; i++) begin
         cap_mask[i] = (4'(i) < cap_count) && (req_data.group_data[8*i +: 8] != 8'd0);
         cap_nz      = cap_nz + {3'd0, cap_mask[i]};
      end
   end

   // Lowest nonzero byte still to send.
   always_comb begin
      low_idx = '0;
      for (int i = zbgp_pkg::GroupBytes - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            low_idx = 3'(i);
         end
      end
   end

   assign len_plus1  = {1'b0, run_length_ff} + 1'b1;
   assign word_plus1 = {1'b0, word_idx_ff} + 1'b1;
   assign word_shift = rdata_ff >> {byte_idx_ff, 3'b000};
   assign data_shift = data_ff >> {byte_idx_ff, 3'b000};
   assign low_shift  = data_ff >> {low_idx, 3'b000};

   always_comb begin
      case (cmd.src)
         zbgp_pkg::SRC_COUNT: emit_byte = {{(8-LenW){1'b0}}, flush_cnt_ff};
         zbgp_pkg::SRC_WORD:  emit_byte = word_shift[7:0];
         zbgp_pkg::SRC_RAW:   emit_byte = data_shift[7:0];
         zbgp_pkg::SRC_HDR:   emit_byte = mask_ff;
         zbgp_pkg::SRC_NZ:    emit_byte = low_shift[7:0];
         default:             emit_byte = mask_ff;
      endcase
   end

   always_comb begin
      status.run_active  = run_active_ff;
      status.join_run    = {1'b0, nz_ff} >= {1'b0, threshold_ff};
      status.end_cond    = last_ff || (count_ff < 4'(zbgp_pkg::GroupBytes)) ||
                           (len_plus1 >= (LenW+1)'(RunLimit));
      status.flush_empty = (flush_len_ff == '0);
      status.words_done  = (word_plus1 == {1'b0, flush_len_ff});
      status.byte_last   = (byte_idx_ff == 3'd7);
      status.raw_empty   = (count_ff == 4'd0);
      status.raw_final   = ({1'b0, byte_idx_ff} + 4'd1 == count_ff);
      status.mask_empty  = (mask_ff == 8'd0);
      status.mask_single = ((mask_ff & (mask_ff - 8'd1)) == 8'd0);
      status.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      run_active_in = run_active_ff;
      run_length_in = run_length_ff;
      threshold_in  = threshold_ff;
      rsp_valid_in  = rsp_valid_ff;
      data_in       = data_ff;
      count_in      = count_ff;
      last_in       = last_ff;
      mask_in       = mask_ff;
      nz_in         = nz_ff;
      byte_idx_in   = byte_idx_ff;
      word_idx_in   = word_idx_ff;
      flush_len_in  = flush_len_ff;
      flush_cnt_in  = flush_cnt_ff;
      rsp_data_in   = rsp_data_ff;

      if (csr_valid) begin
         threshold_in = csr_data;
      end

      if (cmd.capture) begin
         data_in     = req_data.group_data;
         count_in    = cap_count;
         last_in     = req_data.stream_last;
         mask_in     = cap_mask;
         nz_in       = cap_nz;
         byte_idx_in = '0;
      end

      if (cmd.store_word) begin
         run_length_in = len_plus1[LenW-1:0];
      end

      if (cmd.start_flush) begin
         flush_len_in  = run_length_ff;
         flush_cnt_in  = run_length_ff + {{(LenW-1){1'b0}}, cmd.flush_plus1};
         word_idx_in   = '0;
         run_active_in = 1'b0;
         run_length_in = '0;
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.emit) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.out_byte   = emit_byte;
         rsp_data_in.burst_last = cmd.final_byte;
         rsp_data_in.stream_end = cmd.final_byte && last_ff;
         case (cmd.src)
            zbgp_pkg::SRC_WORD: begin
               byte_idx_in = byte_idx_ff + 3'd1;
               if (byte_idx_ff == 3'd7 && word_plus1 != {1'b0, flush_len_ff}) begin
                  word_idx_in = word_plus1[LenW-1:0];
               end
            end
            zbgp_pkg::SRC_RAW: begin
               byte_idx_in = byte_idx_ff + 3'd1;
            end
            zbgp_pkg::SRC_HDR: begin
               // A group of eight nonzero bytes that is not the end of the stream opens a run.
               if (mask_ff == 8'hFF && !last_ff) begin
                  run_active_in = 1'b1;
                  run_length_in = '0;
               end
            end
            zbgp_pkg::SRC_NZ: begin
               mask_in = mask_ff & (mask_ff - 8'd1);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_active_ff <= 1'b0;
         run_length_ff <= '0;
         threshold_ff  <= zbgp_pkg::ThresholdReset;
         rsp_valid_ff  <= 1'b0;
      end else begin
         run_active_ff <= run_active_in;
         run_length_ff <= run_length_in;
         threshold_ff  <= threshold_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff      <= data_in;
      count_ff     <= count_in;
      last_ff      <= last_in;
      mask_ff      <= mask_in;
      nz_ff        <= nz_in;
      byte_idx_ff  <= byte_idx_in;
      word_idx_ff  <= word_idx_in;
      flush_len_ff <= flush_len_in;
      flush_cnt_ff <= flush_cnt_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // Raw run buffer: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.store_word) begin
         run_mem[run_length_ff[AddrW-1:0]] <= data_ff;
      end
      rdata_ff <= run_mem[word_idx_ff[AddrW-1:0]];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== src/zbgp_control.sv =====
// ----------------------------------------------------------------------------
// Zero byte group packer controller
// Sequences capture, run decisions, flushes and byte emission.
// ----------------------------------------------------------------------------
`default_nettype none

module zbgp_control (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  zbgp_pkg::dp_status_type   status,
   output zbgp_pkg::ctl_cmd_type     cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_COUNT,
      ST_FETCH,
      ST_WORD,
      ST_RAW,
      ST_HDR,
      ST_NZ
   } state_type;

   state_type state_ff, state_in;
   logic      tail_raw_ff, tail_raw_in;

   // After a flush, either the joining group follows raw or the group is packed.
   state_type tail_state;
   logic      tail_final;

   always_comb begin
      if (tail_raw_ff) begin
         tail_state = status.raw_empty ? ST_IDLE : ST_RAW;
         tail_final = status.raw_empty;
      end else begin
         tail_state = ST_HDR;
         tail_final = 1'b0;
      end
   end

   always_comb begin
      state_in    = state_ff;
      tail_raw_in = tail_raw_ff;
      cmd         = '0;
      cmd.src     = zbgp_pkg::SRC_HDR;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.run_active) begin
               if (status.join_run && !status.end_cond) begin
                  cmd.store_word = 1'b1;
                  state_in       = ST_IDLE;
               end else begin
                  cmd.start_flush = 1'b1;
                  cmd.flush_plus1 = status.join_run;
                  tail_raw_in     = status.join_run;
                  state_in        = ST_COUNT;
               end
            end else begin
               state_in = ST_HDR;
            end
         end
         ST_COUNT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.src  = zbgp_pkg::SRC_COUNT;
               if (status.flush_empty) begin
                  cmd.final_byte = tail_final;
                  state_in       = tail_state;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_WORD;
         end
         ST_WORD: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.src  = zbgp_pkg::SRC_WORD;
               if (status.byte_last) begin
                  if (status.words_done) begin
                     cmd.final_byte = tail_final;
                     state_in       = tail_state;
                  end else begin
                     state_in = ST_FETCH;
                  end
               end
            end
         end
         ST_RAW: begin
            if (status.out_free) begin
               cmd.emit       = 1'b1;
               cmd.src        = zbgp_pkg::SRC_RAW;
               cmd.final_byte = status.raw_final;
               if (status.raw_final) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_HDR: begin
            if (status.out_free) begin
               cmd.emit       = 1'b1;
               cmd.src        = zbgp_pkg::SRC_HDR;
               cmd.final_byte = status.mask_empty;
               state_in       = status.mask_empty ? ST_IDLE : ST_NZ;
            end
         end
         ST_NZ: begin
            if (status.out_free) begin
               cmd.emit       = 1'b1;
               cmd.src        = zbgp_pkg::SRC_NZ;
               cmd.final_byte = status.mask_single;
               if (status.mask_single) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         tail_raw_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         tail_raw_ff <= tail_raw_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

// ===== src/zero_byte_group_packer_top.sv =====
// ----------------------------------------------------------------------------
// Zero byte group packer top level
// Packs 8-byte groups into bitmap headers, nonzero bytes and raw runs.
// ----------------------------------------------------------------------------
// A group is captured in the idle state and decided in the next cycle; the
// first byte that follows goes to the output register from the count or
// header state. The byte-wide output moves one byte per cycle unless stalled,
// a run flush adds a fetch state per buffered word, and no new group is taken until the last is done.
// Reset is synchronous and active high: it closes any run, empties the output
// register and sets the threshold to 6; the run buffer is not cleared.
`default_nettype none

module zero_byte_group_packer_top #(
   parameter int RunLimit = zbgp_pkg::RunLimitDef
) (
   input  wire                             clock,
   input  wire                             reset,
   // Input group channel.
   input  wire                             req_valid,
   output logic                            req_stall,
   input  zbgp_pkg::req_type               req_data,
   // Packed byte channel.
   output logic                            rsp_valid,
   input  wire                             rsp_stall,
   output zbgp_pkg::rsp_type               rsp_data,
   // Threshold register write channel.
   input  wire                             csr_valid,
   output logic                            csr_ready,
   input  wire [zbgp_pkg::ThresholdW-1:0]  csr_data
);

   zbgp_pkg::ctl_cmd_type   cmd;
   zbgp_pkg::dp_status_type status;

   // The threshold register takes a write transfer in any cycle.
   assign csr_ready = 1'b1;

   // Each group is decided: one that joins an open run is stored; else an
   // optional flush of the buffered raw words (count byte, eight bytes per word)
   // precedes a raw copy of the joining group, or a header plus nonzero bytes.
   zbgp_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath keeps the run state, the raw run buffer and the output
   // register; a byte is loaded only when that register is free or draining,
   // so a stalled transfer on the result side simply holds the controller.
   zbgp_datapath #(
      .RunLimit (RunLimit)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== src/zbgp_checker.sv =====
// ----------------------------------------------------------------------------
// Zero byte group packer checker
// Port-level properties of the packer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module zbgp_checker (
   input wire                             clock,
   input wire                             reset,
   input wire                             req_valid,
   input wire                             req_stall,
   input wire                             rsp_valid,
   input wire                             rsp_stall,
   input zbgp_pkg::rsp_type               rsp_data
);

   // A stalled result transfer keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result payload changed while stalled");

   // The stream end marker only appears on the last byte of an item.
   a_end_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.stream_end |-> rsp_data.burst_last)
      else $error("stream_end without burst_last");

   // One group is worked at a time: an accepted group blocks the next cycle.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted back to back");

   // Reset leaves the block empty and ready.
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind zero_byte_group_packer_top zbgp_checker u_zbgp_checker (.*);

`default_nettype wire
